// File: rtl/fit_pkg.sv
`default_nettype none

package fit_pkg;

	// table geometry
	localparam int RULE_DEPTH   = 16;
	localparam int FILE_ID_BITS = 8;
	localparam int IDX_W        = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CNT_W        = $clog2(RULE_DEPTH + 1);

	localparam int ADDR_BITS  = 48;
	localparam int BYTES_BITS = 32;
	localparam int END_BITS   = ADDR_BITS + 1;

	// io opcodes and error code
	localparam logic OPC_READ  = 1'b0;
	localparam logic OPC_WRITE = 1'b1;
	localparam logic EIO       = 1'b1;

	// item kinds
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// add status codes
	localparam logic [1:0] ADD_NONE   = 2'd0;
	localparam logic [1:0] ADD_STORED = 2'd1;
	localparam logic [1:0] ADD_FULL   = 2'd2;

	typedef enum logic [1:0] {
		KIND_READ_ONCE    = 2'd0,
		KIND_READ_STICKY  = 2'd1,
		KIND_RW_ONCE      = 2'd2,
		KIND_RW_PERMANENT = 2'd3
	} rule_kind_t;

	// one stored rule; the region end is kept inclusive and unwrapped
	typedef struct packed {
		rule_kind_t               kind;
		logic [FILE_ID_BITS-1:0]  file;
		logic [ADDR_BITS-1:0]     first;
		logic [END_BITS-1:0]      last;
	} rule_t;

	// the completed io under test
	typedef struct packed {
		logic                     write;
		logic [FILE_ID_BITS-1:0]  file;
		logic [ADDR_BITS-1:0]     offset;
		logic [END_BITS-1:0]      stop;
	} io_ctx_t;

	typedef struct packed {
		logic match;
		logic removed;
	} hit_t;

endpackage

`default_nettype wire

// File: rtl/io_fault_injection_rule_table_core.sv
// an add item writes its rule in S_ADD; a failed or short io ends the scan at once;
//   a check item scans the stored rules oldest first in S_SCAN and stops at the first hit
// deleting the hit rule moves every younger rule down one slot in S_MOVE
// one item at a time; the next transfer is taken only after the result
//   register loads; a stalled result holds the sequencer
// reset: asynchronous, clears rule count, sequencer and output valid; table contents undefined
`default_nettype none

module io_fault_injection_rule_table_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	// item channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            op,
	input  wire logic [1:0]                      rule_type,
	input  wire logic [fit_pkg::FILE_ID_BITS-1:0] file_id,
	input  wire logic [47:0]                     region_start,
	input  wire logic [47:0]                     region_length,
	input  wire logic                            io_write,
	input  wire logic [47:0]                     io_offset,
	input  wire logic [31:0]                     io_bytes,
	input  wire logic [31:0]                     io_done_bytes,
	input  wire logic                            io_failed,

	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           add_status,
	output logic                                 injected,
	output logic [31:0]                          out_done_bytes,
	output logic                                 out_failed,
	output logic                                 zero_read_data,
	output logic                                 rule_removed
);

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ADD  = 5'b00010,
		S_SCAN = 5'b00100,
		S_MOVE = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// control
	logic [fit_pkg::CNT_W-1:0] count_q;
	logic [fit_pkg::CNT_W-1:0] scan_idx_q;
	logic                      pipe_vld_q;
	logic [fit_pkg::IDX_W-1:0] pipe_idx_q;
	logic [fit_pkg::CNT_W-1:0] mv_src_q;
	logic                      mv_vld_q;
	logic [fit_pkg::IDX_W-1:0] mv_dst_q;
	logic                      out_valid_q;

	// captured item
	logic [1:0]                        kind_q;
	logic [47:0]                       start_q;
	logic [47:0]                       len_q;
	fit_pkg::io_ctx_t                  io_q;
	logic                              io_ok_q;

	// result being built
	logic [1:0]  res_add_q;
	logic        res_inj_q;
	logic [31:0] res_done_q;
	logic        res_fail_q;
	logic        res_zero_q;
	logic        res_rm_q;

	// output register
	logic [1:0]  add_status_q;
	logic        injected_q;
	logic [31:0] done_bytes_q;
	logic        failed_q;
	logic        zero_q;
	logic        removed_q;

	// ram and compare unit
	logic                      ram_we;
	logic [fit_pkg::IDX_W-1:0] ram_waddr;
	fit_pkg::rule_t            ram_wdata;
	logic [fit_pkg::IDX_W-1:0] ram_raddr;
	fit_pkg::rule_t            ram_rdata;
	fit_pkg::rule_t            new_rule;
	fit_pkg::hit_t             hit;

	logic in_xfer;
	logic out_free;
	logic table_full;
	logic scan_end;
	logic move_more;

	assign in_stall   = (state_q != S_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign table_full = (count_q == fit_pkg::CNT_W'(fit_pkg::RULE_DEPTH));
	assign scan_end   = (scan_idx_q == count_q);
	assign move_more  = (mv_src_q < count_q);

	// rule built from the captured add item, end bound formed without wrap
	assign new_rule.kind  = fit_pkg::rule_kind_t'(kind_q);
	assign new_rule.file  = io_q.file;
	assign new_rule.first = start_q;
	assign new_rule.last  = {1'b0, start_q} + {1'b0, len_q};

	// one write port: append on add, shift down during compaction
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = mv_dst_q;
		ram_wdata = ram_rdata;
		ram_raddr = scan_idx_q[fit_pkg::IDX_W-1:0];
		unique case (state_q)
			S_ADD: begin
				ram_we    = !table_full;
				ram_waddr = count_q[fit_pkg::IDX_W-1:0];
				ram_wdata = new_rule;
			end
			S_MOVE: begin
				ram_we    = mv_vld_q;
				ram_raddr = mv_src_q[fit_pkg::IDX_W-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	fit_rule_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fit_match u_match (
		.rule (ram_rdata),
		.io   (io_q),
		.hit  (hit)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			pipe_vld_q  <= 1'b0;
			mv_src_q    <= '0;
			mv_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded when finished, emptied by a transfer
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						scan_idx_q <= '0;
						pipe_vld_q <= 1'b0;
						state_q    <= (op == fit_pkg::OP_ADD) ? S_ADD : S_SCAN;
					end
				end
				S_ADD: begin
					if (!table_full) begin
						count_q <= count_q + fit_pkg::CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (!io_ok_q) begin
						state_q <= S_DONE;
					end else if (pipe_vld_q && hit.match) begin
						pipe_vld_q <= 1'b0;
						if (hit.removed) begin
							mv_src_q <= fit_pkg::CNT_W'(pipe_idx_q) + fit_pkg::CNT_W'(1);
							mv_vld_q <= 1'b0;
							state_q  <= S_MOVE;
						end else begin
							state_q <= S_DONE;
						end
					end else if (scan_end) begin
						// nothing left to read and the last entry missed
						pipe_vld_q <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						pipe_vld_q <= 1'b1;
						scan_idx_q <= scan_idx_q + fit_pkg::CNT_W'(1);
					end
				end
				S_MOVE: begin
					if (move_more) begin
						mv_vld_q <= 1'b1;
						mv_src_q <= mv_src_q + fit_pkg::CNT_W'(1);
					end else begin
						mv_vld_q <= 1'b0;
						if (!mv_vld_q) begin
							count_q <= count_q - fit_pkg::CNT_W'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture, walk indices and result build
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q       <= rule_type;
			start_q      <= region_start;
			len_q        <= region_length;
			io_q.write   <= io_write;
			io_q.file    <= file_id;
			io_q.offset  <= io_offset;
			io_q.stop    <= {1'b0, io_offset} + fit_pkg::END_BITS'(io_bytes);
			io_ok_q      <= !io_failed && (io_done_bytes == io_bytes);
			res_add_q    <= fit_pkg::ADD_NONE;
			res_inj_q    <= 1'b0;
			res_done_q   <= (op == fit_pkg::OP_CHECK) ? io_done_bytes : '0;
			res_fail_q   <= (op == fit_pkg::OP_CHECK) ? io_failed : 1'b0;
			res_zero_q   <= 1'b0;
			res_rm_q     <= 1'b0;
		end
		if (state_q == S_ADD) begin
			res_add_q <= table_full ? fit_pkg::ADD_FULL : fit_pkg::ADD_STORED;
		end
		if (state_q == S_SCAN) begin
			pipe_idx_q <= scan_idx_q[fit_pkg::IDX_W-1:0];
			if (io_ok_q && pipe_vld_q && hit.match) begin
				res_inj_q  <= 1'b1;
				res_done_q <= '0;
				res_fail_q <= fit_pkg::EIO;
				res_zero_q <= (io_q.write == fit_pkg::OPC_READ);
				res_rm_q   <= hit.removed;
			end
		end
		// each moved entry lands one slot below where it was read
		if (state_q == S_MOVE) begin
			mv_dst_q <= mv_src_q[fit_pkg::IDX_W-1:0] - fit_pkg::IDX_W'(1);
		end
		if (state_q == S_DONE && out_free) begin
			add_status_q <= res_add_q;
			injected_q   <= res_inj_q;
			done_bytes_q <= res_done_q;
			failed_q     <= res_fail_q;
			zero_q       <= res_zero_q;
			removed_q    <= res_rm_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign add_status     = add_status_q;
	assign injected       = injected_q;
	assign out_done_bytes = done_bytes_q;
	assign out_failed     = failed_q;
	assign zero_read_data = zero_q;
	assign rule_removed   = removed_q;

endmodule

`default_nettype wire

// File: rtl/fit_rule_ram.sv
`default_nettype none

module fit_rule_ram (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [fit_pkg::IDX_W-1:0] waddr,
	input  wire fit_pkg::rule_t            wdata,
	input  wire logic [fit_pkg::IDX_W-1:0] raddr,
	output fit_pkg::rule_t                 rdata
);

	fit_pkg::rule_t mem_q [fit_pkg::RULE_DEPTH];
	fit_pkg::rule_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fit_match.sv
`default_nettype none

module fit_match (
	input  wire fit_pkg::rule_t   rule,
	input  wire fit_pkg::io_ctx_t io,
	output fit_pkg::hit_t         hit
);

	logic op_ok;
	logic removed;
	logic overlap;

	always_comb begin
		op_ok   = 1'b1;
		removed = 1'b0;
		case (rule.kind)
			fit_pkg::KIND_READ_ONCE: begin
				op_ok   = (io.write == fit_pkg::OPC_READ);
				removed = 1'b1;
			end
			fit_pkg::KIND_READ_STICKY: begin
				op_ok   = (io.write == fit_pkg::OPC_READ);
				removed = (io.write == fit_pkg::OPC_WRITE);
			end
			fit_pkg::KIND_RW_ONCE: begin
				removed = 1'b1;
			end
			default: begin
				removed = 1'b0;
			end
		endcase
	end

	// start strictly before io end, region end (inclusive) at or past io start
	assign overlap = ({1'b0, rule.first} < io.stop) && (rule.last >= {1'b0, io.offset});

	assign hit.match   = (rule.file == io.file) && op_ok && overlap;
	assign hit.removed = removed;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;
	import fit_pkg::*;

	// one item as presented on the item channel
	typedef struct {
		logic                    op;
		rule_kind_t              kind;
		logic [FILE_ID_BITS-1:0] file;
		logic [47:0]             rstart;
		logic [47:0]             rlen;
		logic                    wr;
		logic [47:0]             ioff;
		logic [31:0]             ibytes;
		logic [31:0]             idone;
		logic                    ifail;
	} fit_item_t;

	// one stored fault rule in the scoreboard copy of the table
	typedef struct {
		rule_kind_t              kind;
		logic [FILE_ID_BITS-1:0] file;
		logic [47:0]             base;
		logic [47:0]             span;
	} fault_rule_t;

	// what the block should report for one item
	typedef struct packed {
		logic [1:0]  add_status;
		logic        injected;
		logic [31:0] done_bytes;
		logic        failed;
		logic        zero_read;
		logic        removed;
	} io_verdict_t;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    in_valid       = 1'b0;
	logic                    in_stall;
	logic                    op             = OP_ADD;
	logic [1:0]              rule_type      = 2'd0;
	logic [FILE_ID_BITS-1:0] file_id        = '0;
	logic [47:0]             region_start   = '0;
	logic [47:0]             region_length  = '0;
	logic                    io_write       = OPC_READ;
	logic [47:0]             io_offset      = '0;
	logic [31:0]             io_bytes       = '0;
	logic [31:0]             io_done_bytes  = '0;
	logic                    io_failed      = 1'b0;
	logic                    out_valid;
	logic                    out_stall      = 1'b0;
	logic [1:0]              add_status;
	logic                    injected;
	logic [31:0]             out_done_bytes;
	logic                    out_failed;
	logic                    zero_read_data;
	logic                    rule_removed;

	// scoreboard copy of the rule table, oldest rule at index 0
	fault_rule_t rule_table[$];
	// verdicts still owed by the block, oldest first
	io_verdict_t pending_verdicts[$];

	int fail_count     = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	io_fault_injection_rule_table_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.rule_type      (rule_type),
		.file_id        (file_id),
		.region_start   (region_start),
		.region_length  (region_length),
		.io_write       (io_write),
		.io_offset      (io_offset),
		.io_bytes       (io_bytes),
		.io_done_bytes  (io_done_bytes),
		.io_failed      (io_failed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.add_status     (add_status),
		.injected       (injected),
		.out_done_bytes (out_done_bytes),
		.out_failed     (out_failed),
		.zero_read_data (zero_read_data),
		.rule_removed   (rule_removed)
	);

	always #2 clk = ~clk;

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// apply one accepted item to the scoreboard table and return its verdict
	function automatic io_verdict_t apply_to_table(fit_item_t it);
		io_verdict_t r;
		fault_rule_t rr;
		logic [48:0] io_end;
		logic [48:0] rule_end;
		logic        read_kind;
		logic        drop;
		int          hit_idx;

		r = '0;
		hit_idx = -1;
		if (it.op == OP_ADD) begin
			if (rule_table.size() >= RULE_DEPTH) begin
				r.add_status = ADD_FULL;
			end else begin
				rule_table.push_back('{it.kind, it.file, it.rstart, it.rlen});
				r.add_status = ADD_STORED;
			end
			return r;
		end

		// completion passes unchanged unless a rule applies
		r.add_status = ADD_NONE;
		r.done_bytes = it.idone;
		r.failed     = it.ifail;
		if (it.ifail || it.idone != it.ibytes)
			return r;

		// sums kept one bit wider so nothing wraps
		io_end = {1'b0, it.ioff} + {17'd0, it.ibytes};
		for (int i = 0; i < rule_table.size(); i++) begin
			rr = rule_table[i];
			read_kind = (rr.kind == KIND_READ_ONCE || rr.kind == KIND_READ_STICKY);
			if (rr.file != it.file)
				continue;
			if (read_kind && it.wr != OPC_READ)
				continue;
			rule_end = {1'b0, rr.base} + {1'b0, rr.span};
			// region end is inclusive
			if (!({1'b0, rr.base} < io_end && rule_end >= {1'b0, it.ioff}))
				continue;
			hit_idx = i;
			break;
		end
		if (hit_idx < 0)
			return r;

		rr = rule_table[hit_idx];
		drop = (rr.kind == KIND_READ_ONCE || rr.kind == KIND_RW_ONCE) ||
			(rr.kind == KIND_READ_STICKY && it.wr == OPC_WRITE);
		r.injected   = 1'b1;
		r.done_bytes = '0;
		r.failed     = EIO;
		r.zero_read  = (it.wr == OPC_READ);
		r.removed    = drop;
		// deleting from the queue keeps the order, as the table compacts
		if (drop)
			rule_table.delete(hit_idx);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// result monitor: every transfer on the result channel against the oldest verdict
	always @(posedge clk) begin
		io_verdict_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result expected none got status %0h inj %0b done %0h",
					$time, add_status, injected, out_done_bytes);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("add_status", 32'(want.add_status), 32'(add_status));
				check_field("injected", 32'(want.injected), 32'(injected));
				check_field("out_done_bytes", want.done_bytes, out_done_bytes);
				check_field("out_failed", 32'(want.failed), 32'(out_failed));
				check_field("zero_read_data", 32'(want.zero_read), 32'(zero_read_data));
				check_field("rule_removed", 32'(want.removed), 32'(rule_removed));
			end
		end
	end

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	// mostly a handful of files so that rules and completions meet
	function automatic logic [FILE_ID_BITS-1:0] pick_file();
		if ($urandom_range(99) < 70)
			return FILE_ID_BITS'($urandom_range(3));
		return FILE_ID_BITS'($urandom);
	endfunction

	function automatic fit_item_t make_add(rule_kind_t kind, logic [FILE_ID_BITS-1:0] file,
			logic [47:0] rstart, logic [47:0] rlen);
		fit_item_t it;
		it = '{OP_ADD, kind, file, rstart, rlen, OPC_READ, 48'd0, 32'd0, 32'd0, 1'b0};
		return it;
	endfunction

	function automatic fit_item_t make_check(logic wr, logic [FILE_ID_BITS-1:0] file,
			logic [47:0] ioff, logic [31:0] ibytes, logic [31:0] idone, logic ifail);
		fit_item_t it;
		it = '{OP_CHECK, KIND_READ_ONCE, file, 48'd0, 48'd0, wr, ioff, ibytes, idone, ifail};
		return it;
	endfunction

	// entered and left on a falling edge; valid drops on the falling edge after the
	// transfer and the task then returns, while the block is still busy
	task automatic send_item(fit_item_t it);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(negedge clk);
		end
		op            <= it.op;
		rule_type     <= it.kind;
		file_id       <= it.file;
		region_start  <= it.rstart;
		region_length <= it.rlen;
		io_write      <= it.wr;
		io_offset     <= it.ioff;
		io_bytes      <= it.ibytes;
		io_done_bytes <= it.idone;
		io_failed     <= it.ifail;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_verdicts.push_back(apply_to_table(it));
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	// sender holds off until the block has answered everything
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_verdicts.size() != 0)
			@(negedge clk);
	endtask

	// walk over an empty table with a clean, all-ones completion
	task automatic test_empty_table();
		send_item(make_check(OPC_WRITE, '1, '1, '1, '1, 1'b0));
	endtask

	// each rule kind: opcode filter, region bounds, removal and the pass-through cases
	task automatic test_rule_kinds();
		logic [47:0] far_base;
		far_base = 48'h8000_0000_0000;

		// read once with a zero length region at offset zero
		send_item(make_add(KIND_READ_ONCE, 8'h00, 48'd0, 48'd0));
		send_item(make_check(OPC_WRITE, 8'h00, 48'd0, 32'd1, 32'd1, 1'b0));
		// zero length io ends where it starts, so no overlap
		send_item(make_check(OPC_READ, 8'h00, 48'd0, 32'd0, 32'd0, 1'b0));
		send_item(make_check(OPC_READ, 8'h00, 48'd0, 32'd1, 32'd1, 1'b0));

		// sticky rule at the very top of the address space, region end beyond 48 bits
		send_item(make_add(KIND_READ_STICKY, 8'hFF, '1, '1));
		send_item(make_check(OPC_READ, 8'hFF, '1, '1, '1, 1'b0));
		// short and already failed transfer is passed through
		send_item(make_check(OPC_READ, 8'hFF, '1, 32'd8, 32'd7, 1'b1));

		// read-write once hit on the inclusive last byte
		send_item(make_add(KIND_RW_ONCE, 8'h5A, 48'd1000, 48'd100));
		send_item(make_check(OPC_WRITE, 8'h5A, 48'd1100, 32'd4, 32'd4, 1'b0));

		// permanent rule: hit on its end byte, miss when the io stops right before it
		send_item(make_add(KIND_RW_PERMANENT, 8'hA5, far_base, 48'd16));
		send_item(make_check(OPC_WRITE, 8'hA5, far_base + 48'd16, 32'd1, 32'd1, 1'b0));
		send_item(make_check(OPC_READ, 8'hA5, far_base - 48'd8, 32'd8, 32'd8, 1'b0));
	endtask

	// fill up with once rules, then one add too many
	task automatic test_table_full();
		int n;
		n = 0;
		while (rule_table.size() < RULE_DEPTH) begin
			send_item(make_add((n % 2) ? KIND_RW_ONCE : KIND_READ_ONCE,
				FILE_ID_BITS'(n % 4), 48'(n * 4096), 48'd4095));
			n++;
		end
		wait_drained();
		send_item(make_add(KIND_RW_PERMANENT, 8'h33, 48'd0, 48'd1));
	endtask

	// mostly completions aimed at stored rules, around their edges, plus adds and noise
	task automatic test_random_traffic(int count, int src_pct, int sink_pct);
		fit_item_t   it;
		fault_rule_t rr;
		logic [48:0] reach;
		logic [31:0] k;
		int          add_pct;
		int          persistent;

		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (int n = 0; n < count; n++) begin
			// random content in every field, ignored parts included
			it = make_check(1'($urandom_range(1)), pick_file(), rand48(), $urandom, $urandom,
				1'($urandom_range(1)));
			it.kind   = rule_kind_t'($urandom_range(3));
			it.rstart = rand48();
			it.rlen   = rand48();
			add_pct = (rule_table.size() >= RULE_DEPTH) ? 15 : 45;

			if ($urandom_range(99) < add_pct) begin
				it.op = OP_ADD;
				// sticky and permanent rules never leave, so keep them few and narrow
				persistent = 0;
				foreach (rule_table[i])
					if (rule_table[i].kind == KIND_READ_STICKY ||
							rule_table[i].kind == KIND_RW_PERMANENT)
						persistent++;
				if (persistent >= 6)
					it.kind = $urandom_range(1) ? KIND_RW_ONCE : KIND_READ_ONCE;
				case ($urandom_range(4))
					0: it.rstart = '0;
					1: it.rstart = '1;
					2: it.rstart = 48'($urandom_range(65535));
					3: it.rstart = 48'hFFFF_0000_0000 + 48'($urandom);
					default: it.rstart = rand48();
				endcase
				case ($urandom_range(3))
					0: it.rlen = '0;
					1: it.rlen = '1;
					2: it.rlen = 48'($urandom_range(4095));
					default: it.rlen = rand48();
				endcase
				if (it.kind == KIND_READ_STICKY || it.kind == KIND_RW_PERMANENT)
					it.rlen = 48'($urandom_range(255));
			end else begin
				it.op = OP_CHECK;
				if ($urandom_range(15) == 0)
					k = '0;
				else if ($urandom_range(3) == 0)
					k = $urandom;
				else
					k = $urandom_range(4096, 1);
				if (rule_table.size() != 0 && $urandom_range(99) < 75) begin
					rr = rule_table[$urandom_range(rule_table.size() - 1)];
					it.file = rr.file;
					if (rr.kind == KIND_READ_ONCE || rr.kind == KIND_READ_STICKY)
						it.wr = ($urandom_range(99) < 85) ? OPC_READ : OPC_WRITE;
					reach = {1'b0, rr.base} + {1'b0, rr.span};
					case ($urandom_range(4))
						0: it.ioff = reach[47:0];                       // last byte of region
						1: it.ioff = reach[47:0] + 48'd1;               // just past the end
						2: it.ioff = rr.base - {16'd0, k};              // io stops at region start
						3: it.ioff = rr.base - {16'd0, k} + 48'd1;      // io overlaps first byte
						default:
							it.ioff = rr.base +
								48'({1'b0, rand48()} % ({1'b0, rr.span} + 49'd1));
					endcase
				end
				it.ibytes = k;
				it.idone  = ($urandom_range(99) < 90) ? k : $urandom;
				it.ifail  = ($urandom_range(99) < 8);
			end
			send_item(it);
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_table();
		test_rule_kinds();
		test_table_full();
		wait_drained();

		// receiver stalls heavier, then sender gaps heavier, then full rate
		test_random_traffic(300, 35, 52);
		test_random_traffic(300, 52, 35);
		test_random_traffic(300, 0, 0);

		// let any stray result show up
		repeat (64) @(posedge clk);
		if (fail_count == 0 && pending_verdicts.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
rtl/fit_pkg.sv
rtl/fit_rule_ram.sv
rtl/fit_match.sv
rtl/io_fault_injection_rule_table_core.sv
sim/tb_top.sv
